>>> hw/rtl/cascade_pid_with_direction_split_top_assert.svh
// Assertion macros used by the checker module of the cascade PID block.
`ifndef CASCADE_PID_WITH_DIRECTION_SPLIT_TOP_ASSERT_SVH
`define CASCADE_PID_WITH_DIRECTION_SPLIT_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CPID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/cpid_pkg.sv
// Package with types and constants of the cascade PID block.
`default_nettype none
package cpid_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] RegAngleGains = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleLimits = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedGains = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpeedLimits = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFwdGains = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRevGains = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCurLimits = 3'd6;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirFwd = 2'd1;
  localparam logic [1:0] DirRev = 2'd2;

  typedef struct packed {
    logic        chain_mode;
    logic signed [15:0] setpoint;
    logic signed [15:0] angle_measured;
    logic signed [15:0] speed_measured;
    logic signed [15:0] current_measured;
    logic [15:0] time_step;
  } req_t;

  typedef struct packed {
    logic signed [15:0] current_drive;
    logic signed [15:0] speed_drive;
    logic signed [15:0] angle_drive;
    logic [1:0]  direction;
    logic        step_invalid;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  // Control between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic signed [33:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [33:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hw/rtl/cpid_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none
interface cpid_req_if import cpid_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpid_rsp_if import cpid_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpid_cfg_if import cpid_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cpid_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module cpid_div import cpid_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  localparam int unsigned NumW = 33;
  logic [NumW-1:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;
  logic [16:0] shifted;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[15:0], num_q[NumW-1]};
    trial = {1'b0, shifted} - {2'b00, den_q};
    if (req_i.start) begin
      neg_d = req_i.dividend[33];
      num_d = req_i.dividend[33] ? NumW'(-req_i.dividend) : NumW'(req_i.dividend);
      den_d = req_i.divisor;
      rem_d = '0;
      cnt_d = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
endmodule
`default_nettype wire

>>> hw/rtl/cpid_loop.sv
// Sequencer that runs one PID evaluation at a time over a shared multiplier and divider.
`default_nettype none
module cpid_loop import cpid_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [47:0]        gains_i,
  input  wire logic [47:0]        limits_i,
  input  wire logic signed [31:0] acc_i,
  input  wire logic signed [16:0] last_i,
  input  wire logic signed [15:0] target_i,
  input  wire logic signed [15:0] meas_i,
  input  wire logic [15:0]        dt_i,
  output logic                    done_o,
  output logic signed [15:0]      out_o,
  output logic signed [31:0]      acc_o,
  output logic signed [16:0]      err_o
);
  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StInt  = 7'b0000010,
    StDiv  = 7'b0000100,
    StWait = 7'b0001000,
    StKi   = 7'b0010000,
    StKd   = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic signed [16:0] err_q;
  logic signed [31:0] acc_q;
  logic signed [33:0] deriv_q;
  logic signed [51:0] sum_q;
  logic signed [15:0] out_q;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  logic signed [34:0] int_sum;
  logic signed [34:0] ilim;
  logic signed [51:0] sum_sh;
  logic signed [51:0] olim;
  logic signed [51:0] clamped;
  div_req_t div_req;
  div_rsp_t div_rsp;

  cpid_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  assign ilim = limits_i[31] ? 35'sh7FFFFFFF : $signed({3'b000, limits_i[31:0]});
  assign olim = $signed({36'd0, limits_i[47:32]});

  always_comb begin
    mul_a = 34'(err_q);
    mul_b = $signed({17'd0, dt_i});
    case (state_q)
      StKi: begin
        mul_a = 34'(acc_q);
        mul_b = $signed({17'd0, gains_i[31:16]});
      end
      StKd: begin
        mul_a = deriv_q;
        mul_b = $signed({17'd0, gains_i[47:32]});
      end
      StDiv: begin
        mul_a = 34'(err_q);
        mul_b = $signed({17'd0, gains_i[15:0]});
      end
      default: ;
    endcase
    prod = 67'(mul_a * mul_b);
  end

  assign int_sum = 35'(acc_i) + 35'(prod);
  assign sum_sh = sum_q >>> 8;
  assign clamped = (sum_sh > olim) ? olim : ((sum_sh < -olim) ? -olim : sum_sh);

  always_comb begin
    state_d = state_q;
    div_req.start = 1'b0;
    div_req.dividend = $signed({18'(err_q) - 18'(last_i), 16'd0});
    div_req.divisor = dt_i;
    case (state_q)
      StIdle: if (start_i) state_d = StInt;
      StInt: state_d = StDiv;
      StDiv: begin
        div_req.start = 1'b1;
        state_d = StWait;
      end
      StWait: if (div_rsp.done) state_d = StKi;
      StKi: state_d = StKd;
      StKd: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (start_i) err_q <= 17'(target_i) - 17'(meas_i);
      StInt: begin
        if (int_sum > ilim) acc_q <= 32'(ilim);
        else if (int_sum < -ilim) acc_q <= 32'(-ilim);
        else acc_q <= 32'(int_sum);
      end
      StDiv: sum_q <= 52'(prod);
      StWait: if (div_rsp.done) deriv_q <= div_rsp.quotient;
      StKi: sum_q <= sum_q + 52'(prod >>> 16);
      StKd: sum_q <= sum_q + 52'(prod);
      StOut: begin
        if (clamped > 52'sd32767) out_q <= 16'sh7FFF;
        else if (clamped < -52'sd32768) out_q <= 16'sh8000;
        else out_q <= 16'(clamped);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= (state_q == StOut);
  end

  assign out_o = out_q;
  assign acc_o = acc_q;
  assign err_o = err_q;
endmodule
`default_nettype wire

>>> hw/rtl/cascade_pid_with_direction_split_top.sv
// Top level of the cascade PID block: registers, loop state and the tick sequencer.
// One request is in flight at a time; a zero time step skips every loop and answers with
// step_invalid set and zero drives. Each loop evaluation runs the 33-step serial divider
// in the shared loop unit.
// Reset clears all configuration registers, integrals, last errors and the active direction.
`default_nettype none
module cascade_pid_with_direction_split_top import cpid_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  cpid_req_if.sink   req,
  cpid_rsp_if.source rsp,
  cpid_cfg_if.sink   cfg
);
  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SAng  = 6'b000010,
    SSpd  = 6'b000100,
    SDir  = 6'b001000,
    SCur  = 6'b010000,
    SRsp  = 6'b100000
  } seq_e;

  seq_e seq_q;
  logic [47:0] regs_q [7];
  logic signed [31:0] acc_q [4];
  logic signed [16:0] last_q [4];
  logic [1:0] dir_q;
  req_t in_q;
  rsp_t out_q;
  logic rvalid_q, start_q;
  logic [1:0] sel_q;
  logic [47:0] gains, limits;
  logic signed [15:0] target, meas;
  logic ldone;
  logic signed [15:0] lout;
  logic signed [31:0] lacc;
  logic signed [16:0] lerr;

  assign cfg.ready = 1'b1;
  assign req.ready = (seq_q == SIdle) && !rvalid_q;
  assign rsp.valid = rvalid_q;
  assign rsp.data = out_q;

  always_comb begin
    gains = regs_q[RegAngleGains];
    limits = regs_q[RegAngleLimits];
    target = in_q.setpoint;
    meas = in_q.angle_measured;
    case (sel_q)
      2'd1: begin
        gains = regs_q[RegSpeedGains];
        limits = regs_q[RegSpeedLimits];
        target = in_q.chain_mode ? out_q.angle_drive : in_q.setpoint;
        meas = in_q.speed_measured;
      end
      2'd2, 2'd3: begin
        gains = (sel_q == 2'd2) ? regs_q[RegFwdGains] : regs_q[RegRevGains];
        limits = regs_q[RegCurLimits];
        target = out_q.speed_drive;
        meas = in_q.current_measured;
      end
      default: ;
    endcase
  end

  cpid_loop u_loop (
    .clk_i, .rst_ni, .start_i(start_q), .gains_i(gains), .limits_i(limits),
    .acc_i(acc_q[sel_q]), .last_i(last_q[sel_q]), .target_i(target), .meas_i(meas),
    .dt_i(in_q.time_step), .done_o(ldone), .out_o(lout), .acc_o(lacc), .err_o(lerr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SIdle;
      rvalid_q <= 1'b0;
      start_q <= 1'b0;
      sel_q <= '0;
      dir_q <= DirNone;
      for (int i = 0; i < 7; i++) regs_q[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= '0;
        last_q[i] <= '0;
      end
    end else begin
      start_q <= 1'b0;
      if (cfg.valid && cfg.data.index <= RegCurLimits) regs_q[cfg.data.index] <= cfg.data.data;
      if (rsp.valid && rsp.ready) rvalid_q <= 1'b0;
      case (seq_q)
        SIdle: if (req.valid && req.ready) begin
          if (req.data.time_step == '0) begin
            seq_q <= SRsp;
          end else begin
            sel_q <= req.data.chain_mode ? 2'd0 : 2'd1;
            start_q <= 1'b1;
            seq_q <= req.data.chain_mode ? SAng : SSpd;
          end
        end
        SAng: if (ldone) begin
          acc_q[0] <= lacc;
          last_q[0] <= lerr;
          sel_q <= 2'd1;
          start_q <= 1'b1;
          seq_q <= SSpd;
        end
        SSpd: if (ldone) begin
          acc_q[1] <= lacc;
          last_q[1] <= lerr;
          seq_q <= SDir;
        end
        SDir: begin
          if (out_q.speed_drive == '0) begin
            for (int i = 2; i < 4; i++) begin
              acc_q[i] <= '0;
              last_q[i] <= '0;
            end
            dir_q <= DirNone;
            seq_q <= SRsp;
          end else begin
            if (!out_q.speed_drive[15] && dir_q != DirFwd) begin
              acc_q[2] <= '0;
              last_q[2] <= '0;
            end
            if (out_q.speed_drive[15] && dir_q != DirRev) begin
              acc_q[3] <= '0;
              last_q[3] <= '0;
            end
            dir_q <= out_q.speed_drive[15] ? DirRev : DirFwd;
            sel_q <= out_q.speed_drive[15] ? 2'd3 : 2'd2;
            start_q <= 1'b1;
            seq_q <= SCur;
          end
        end
        SCur: if (ldone) begin
          acc_q[sel_q] <= lacc;
          last_q[sel_q] <= lerr;
          seq_q <= SRsp;
        end
        SRsp: begin
          rvalid_q <= 1'b1;
          seq_q <= SIdle;
        end
        default: seq_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_q <= req.data;
      out_q.current_drive <= '0;
      out_q.speed_drive <= '0;
      out_q.angle_drive <= '0;
      out_q.step_invalid <= (req.data.time_step == '0);
    end
    if (seq_q == SAng && ldone) out_q.angle_drive <= lout;
    if (seq_q == SSpd && ldone) out_q.speed_drive <= lout;
    if (seq_q == SCur && ldone) out_q.current_drive <= lout;
    if (seq_q == SRsp) out_q.direction <= dir_q;
  end
endmodule
`default_nettype wire

>>> hw/rtl/cpid_checker.sv
// Port-level checker for the cascade PID block, bound to the top level.
`default_nettype none
`include "cascade_pid_with_direction_split_top_assert.svh"
module cpid_checker import cpid_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  `CPID_ASSERT_IMP(a_busy_no_req, clk_i, rst_ni, rsp_valid, !req_ready)
  `CPID_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid && req_ready, !req_ready)
  `CPID_ASSERT_IMP(a_dir_code, clk_i, rst_ni, rsp_valid, rsp_data.direction != 2'd3)
  `CPID_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, rsp_valid && rsp_data.step_invalid,
                   rsp_data.current_drive == '0 && rsp_data.speed_drive == '0)
  `CPID_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data))
endmodule

bind cascade_pid_with_direction_split_top cpid_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
